// ===== hdl/stgm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stgm_pkg: shared types and constants of the stereo tremolo gain modulator
// Field widths, register and command codes, divider sizing and the
// controller-to-datapath command and status structs.
// ----------------------------------------------------------------------------
package stgm_pkg;

    // Field widths
    localparam int SAMPLE_BITS      = 24;
    localparam int PERIOD_BITS      = 20;
    localparam int GAIN_BITS        = 17;
    localparam int PHASE_BITS       = 16;
    localparam int BENT_SHIFT       = 15;
    localparam int SHAPE_BITS       = 16;
    localparam int CURVE_INDEX_BITS = 8;
    localparam int CMD_BITS         = 2;
    localparam int CFG_INDEX_BITS   = 2;

    // Gain curve memory; depth is a power of two
    localparam int CURVE_DEPTH     = 256;
    localparam int CURVE_ADDR_BITS = $clog2(CURVE_DEPTH);

    // Configuration data is as wide as the widest register
    localparam int CFG_DATA_BITS = (PERIOD_BITS > GAIN_BITS) ? PERIOD_BITS : GAIN_BITS;

    // Q16 unity gain and product width (signed sample times unsigned gain)
    localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(65536);
    localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;

    // Register reset values
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(48000);
    localparam logic [PERIOD_BITS-1:0] OFFSET_RESET = '0;
    localparam logic [SHAPE_BITS-1:0]  SHAPE_RESET  = SHAPE_BITS'(32768);
    localparam logic [GAIN_BITS-1:0]   STEP_RESET   = GAIN_BITS'(66);

    // Restoring divider sizing: numerator holds rel << 16 or phase << 15
    localparam int DIV_NUM_BITS =
        (PERIOD_BITS + PHASE_BITS > PHASE_BITS + BENT_SHIFT) ?
        (PERIOD_BITS + PHASE_BITS) : (PHASE_BITS + BENT_SHIFT);
    localparam int DIV_DEN_BITS =
        (PERIOD_BITS > SHAPE_BITS + 1) ? PERIOD_BITS : (SHAPE_BITS + 1);
    localparam int DIV_CNT_BITS = $clog2(DIV_NUM_BITS + 1);

    // Item commands
    typedef enum logic [CMD_BITS-1:0] {
        CMD_FRAME    = 2'd0,
        CMD_RESYNC   = 2'd1,
        CMD_CURVE    = 2'd2,
        CMD_RESERVED = 2'd3
    } item_cmd_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_PERIOD = 2'd0,
        REG_OFFSET = 2'd1,
        REG_SHAPE  = 2'd2,
        REG_STEP   = 2'd3
    } cfg_reg_t;

    // Divider operand selection
    typedef enum logic [2:0] {
        DIV_POS,
        DIV_OFF,
        DIV_PHASE,
        DIV_BENT,
        DIV_SYNC
    } div_kind_t;

    // Controller to datapath commands
    typedef struct packed {
        logic      capture;
        logic      curve_write;
        logic      div_load;
        div_kind_t div_kind;
        logic      div_step;
        logic      pos_store;
        logic      gain_update;
        logic      mul;
        logic      out_load;
        logic      sync_store;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // Quotient bits produced for each divider operand
    function automatic logic [DIV_CNT_BITS-1:0] div_iters(input div_kind_t kind);
        logic [DIV_CNT_BITS-1:0] n;
        case (kind)
            DIV_PHASE: n = DIV_CNT_BITS'(PERIOD_BITS + PHASE_BITS);
            DIV_BENT:  n = DIV_CNT_BITS'(PHASE_BITS + BENT_SHIFT);
            default:   n = DIV_CNT_BITS'(PERIOD_BITS);
        endcase
        return n;
    endfunction

endpackage

// ===== hdl/stgm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stgm_in_if / stgm_out_if: item and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface stgm_in_if
    import stgm_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic [CMD_BITS-1:0]           cmd;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic [PERIOD_BITS-1:0]        start_frame;
    logic [CURVE_INDEX_BITS-1:0]   curve_index;
    logic [GAIN_BITS-1:0]          curve_value;

    modport source (
        output valid, cmd, left_in, right_in, start_frame, curve_index, curve_value,
        input  ready
    );
    modport sink (
        input  valid, cmd, left_in, right_in, start_frame, curve_index, curve_value,
        output ready
    );
endinterface

interface stgm_out_if
    import stgm_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;

    modport source (
        output valid, left_out, right_out,
        input  ready
    );
    modport sink (
        input  valid, left_out, right_out,
        output ready
    );
endinterface

// ===== hdl/stgm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stgm_datapath: registers, serial divider, gain curve and multipliers
// Holds configuration, frame position and gain; runs one restoring
// division step per cycle and the slew, scale and output steps on command.
// ----------------------------------------------------------------------------
module stgm_datapath
    import stgm_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  dp_cmd_t                       cmd,
    output dp_status_t                    status,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] left_in,
    input  logic signed [SAMPLE_BITS-1:0] right_in,
    input  logic [PERIOD_BITS-1:0]        start_frame,
    input  logic [CURVE_INDEX_BITS-1:0]   curve_index,
    input  logic [GAIN_BITS-1:0]          curve_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out
);

    localparam int TOP_PERIOD = DIV_NUM_BITS - PERIOD_BITS;
    localparam int TOP_PHASE  = DIV_NUM_BITS - PHASE_BITS;

    // Configuration registers
    logic [PERIOD_BITS-1:0] period_reg;
    logic [PERIOD_BITS-1:0] offset_reg;
    logic [SHAPE_BITS-1:0]  shape_reg;
    logic [GAIN_BITS-1:0]   step_reg;

    // State and payload registers
    logic [PERIOD_BITS-1:0]        frame_pos_reg, frame_pos_next;
    logic [GAIN_BITS-1:0]          gain_reg, gain_next;
    logic signed [SAMPLE_BITS-1:0] left_reg, right_reg;
    logic [PERIOD_BITS-1:0]        start_reg;
    logic                          seg_upper_reg;

    // Divider registers
    logic [DIV_NUM_BITS-1:0] num_reg, num_next;
    logic [DIV_DEN_BITS-1:0] rem_reg, rem_next;
    logic [DIV_DEN_BITS-1:0] den_reg, den_next;
    logic                    seg_upper_next;

    // Gain curve memory and products
    logic [GAIN_BITS-1:0]        curve_mem [CURVE_DEPTH];
    logic [GAIN_BITS-1:0]        curve_rdata_reg;
    logic [CURVE_ADDR_BITS-1:0]  rd_addr;
    logic [GAIN_BITS-1:0]        curve_wdata;
    logic signed [PROD_BITS-1:0] prod_l_reg, prod_r_reg;
    logic                        out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] left_out_reg, right_out_reg;

    logic [PERIOD_BITS-1:0] eff_period;
    logic [PERIOD_BITS-1:0] off_mod;
    logic [PERIOD_BITS:0]   wrap_sum;
    logic [PERIOD_BITS-1:0] rel;
    logic [PHASE_BITS-1:0]  phase;
    logic [PHASE_BITS-1:0]  quot;
    logic [PHASE_BITS-1:0]  bent;
    logic [DIV_DEN_BITS:0]  trial;
    logic [DIV_DEN_BITS:0]  diff;
    logic                   ge;
    logic [PERIOD_BITS:0]   pos_inc;
    logic [GAIN_BITS:0]     gain_up;
    logic [GAIN_BITS:0]     target_up;

    // Period zero counts as one
    assign eff_period = (period_reg == '0) ? PERIOD_BITS'(1) : period_reg;

    // Relative position from the reduced position and reduced offset
    assign off_mod  = rem_reg[PERIOD_BITS-1:0];
    assign wrap_sum = {1'b0, frame_pos_reg} + {1'b0, eff_period} - {1'b0, off_mod};
    assign rel = (frame_pos_reg >= off_mod) ? (frame_pos_reg - off_mod)
                                            : wrap_sum[PERIOD_BITS-1:0];

    // Quotient sits in the low bits once a division is done
    assign quot  = num_reg[PHASE_BITS-1:0];
    assign phase = quot;
    assign bent  = seg_upper_reg ? (PHASE_BITS'(32768) + quot) : quot;
    assign rd_addr = bent[PHASE_BITS-1 -: CURVE_ADDR_BITS];

    // One restoring division step
    assign trial = {rem_reg, num_reg[DIV_NUM_BITS-1]};
    assign ge    = (trial >= {1'b0, den_reg});
    assign diff  = trial - {1'b0, den_reg};

    // Load or step the divider
    always_comb
    begin
        num_next       = num_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        seg_upper_next = seg_upper_reg;
        if (cmd.div_load)
        begin
            rem_next = '0;
            den_next = DIV_DEN_BITS'(eff_period);
            case (cmd.div_kind)
                DIV_POS:   num_next = DIV_NUM_BITS'(frame_pos_reg) << TOP_PERIOD;
                DIV_OFF:   num_next = DIV_NUM_BITS'(offset_reg) << TOP_PERIOD;
                DIV_PHASE: num_next = DIV_NUM_BITS'(rel) << TOP_PERIOD;
                DIV_BENT:
                begin
                    if (phase < shape_reg)
                    begin
                        num_next       = DIV_NUM_BITS'(phase) << TOP_PHASE;
                        den_next       = DIV_DEN_BITS'(shape_reg);
                        seg_upper_next = 1'b0;
                    end
                    else
                    begin
                        num_next       = DIV_NUM_BITS'(phase - shape_reg) << TOP_PHASE;
                        den_next       = DIV_DEN_BITS'(GAIN_ONE - GAIN_BITS'(shape_reg));
                        seg_upper_next = 1'b1;
                    end
                end
                DIV_SYNC:  num_next = DIV_NUM_BITS'(start_reg) << TOP_PERIOD;
                default:   num_next = num_reg;
            endcase
        end
        else if (cmd.div_step)
        begin
            num_next = {num_reg[DIV_NUM_BITS-2:0], ge};
            rem_next = ge ? diff[DIV_DEN_BITS-1:0] : trial[DIV_DEN_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg       <= num_next;
        rem_reg       <= rem_next;
        den_reg       <= den_next;
        seg_upper_reg <= seg_upper_next;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            offset_reg <= OFFSET_RESET;
            shape_reg  <= SHAPE_RESET;
            step_reg   <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PERIOD: period_reg <= cfg_data[PERIOD_BITS-1:0];
                REG_OFFSET: offset_reg <= cfg_data[PERIOD_BITS-1:0];
                REG_SHAPE:  shape_reg  <= cfg_data[SHAPE_BITS-1:0];
                REG_STEP:   step_reg   <= cfg_data[GAIN_BITS-1:0];
                default:    ;
            endcase
        end
    end

    // Capture the item payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            left_reg  <= left_in;
            right_reg <= right_in;
            start_reg <= start_frame;
        end
    end

    // Saturate and write curve entries; read with a registered port
    assign curve_wdata = (curve_value > GAIN_ONE) ? GAIN_ONE : curve_value;

    always_ff @(posedge clk)
    begin
        if (cmd.curve_write && (32'(curve_index) < CURVE_DEPTH))
        begin
            curve_mem[CURVE_ADDR_BITS'(curve_index)] <= curve_wdata;
        end
        curve_rdata_reg <= curve_mem[rd_addr];
    end

    // Frame position: reduce, advance with wrap, or resync
    assign pos_inc = {1'b0, frame_pos_reg} + (PERIOD_BITS + 1)'(1);

    always_comb
    begin
        frame_pos_next = frame_pos_reg;
        if (cmd.pos_store || cmd.sync_store)
        begin
            frame_pos_next = rem_reg[PERIOD_BITS-1:0];
        end
        else if (cmd.out_load)
        begin
            frame_pos_next = (pos_inc >= {1'b0, eff_period}) ? '0
                                                              : pos_inc[PERIOD_BITS-1:0];
        end
    end

    // Slew the gain toward the curve target
    assign gain_up   = {1'b0, gain_reg} + {1'b0, step_reg};
    assign target_up = {1'b0, curve_rdata_reg} + {1'b0, step_reg};

    always_comb
    begin
        gain_next = gain_reg;
        if (cmd.sync_store)
        begin
            gain_next = '0;
        end
        else if (cmd.gain_update)
        begin
            if ({1'b0, curve_rdata_reg} > gain_up)
            begin
                gain_next = gain_up[GAIN_BITS-1:0];
            end
            else if (target_up < {1'b0, gain_reg})
            begin
                gain_next = gain_reg - step_reg;
            end
            else
            begin
                gain_next = curve_rdata_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pos_reg <= '0;
            gain_reg      <= '0;
        end
        else
        begin
            frame_pos_reg <= frame_pos_next;
            gain_reg      <= gain_next;
        end
    end

    // Scale both samples by the gain
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_l_reg <= PROD_BITS'(left_reg) * $signed({1'b0, gain_reg});
            prod_r_reg <= PROD_BITS'(right_reg) * $signed({1'b0, gain_reg});
        end
    end

    // Output register; floor shift is the part-select starting at bit 16
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            left_out_reg  <= prod_l_reg[16 +: SAMPLE_BITS];
            right_out_reg <= prod_r_reg[16 +: SAMPLE_BITS];
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

endmodule

// ===== hdl/stgm_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stgm_controller: item sequencer
// Accepts items, steps the shared divider through its four operands for a
// frame, then lookup, slew, scale and output; a resync uses one operand.
// ----------------------------------------------------------------------------
module stgm_controller
    import stgm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [CMD_BITS-1:0] in_cmd,
    output logic                in_ready,
    output dp_cmd_t             cmd,
    input  dp_status_t          status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_READ,
        S_SLEW,
        S_MUL,
        S_OUT,
        S_SYNC_END
    } state_t;

    state_t                  state_reg, state_next;
    div_kind_t               kind_reg, kind_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.div_kind = kind_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (item_cmd_t'(in_cmd))
                        CMD_FRAME:
                        begin
                            kind_next  = DIV_POS;
                            state_next = S_LOAD;
                        end
                        CMD_RESYNC:
                        begin
                            kind_next  = DIV_SYNC;
                            state_next = S_LOAD;
                        end
                        CMD_CURVE: cmd.curve_write = 1'b1;
                        default:   ;
                    endcase
                end
            end
            S_LOAD:
            begin
                // Keep the reduced position before the offset is divided
                cmd.div_load  = 1'b1;
                cmd.pos_store = (kind_reg == DIV_OFF);
                cnt_next      = div_iters(kind_reg) - DIV_CNT_BITS'(1);
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - DIV_CNT_BITS'(1);
                if (cnt_reg == '0)
                begin
                    case (kind_reg)
                        DIV_POS:
                        begin
                            kind_next  = DIV_OFF;
                            state_next = S_LOAD;
                        end
                        DIV_OFF:
                        begin
                            kind_next  = DIV_PHASE;
                            state_next = S_LOAD;
                        end
                        DIV_PHASE:
                        begin
                            kind_next  = DIV_BENT;
                            state_next = S_LOAD;
                        end
                        DIV_BENT: state_next = S_READ;
                        DIV_SYNC: state_next = S_SYNC_END;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_READ: state_next = S_SLEW;
            S_SLEW:
            begin
                cmd.gain_update = 1'b1;
                state_next      = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // Hold until the output register is free
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SYNC_END:
            begin
                cmd.sync_store = 1'b1;
                state_next     = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= DIV_POS;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== hdl/stereo_tremolo_gain_modulator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_tremolo_gain_modulator_top: stereo tremolo gain modulator
// Scales stereo frames by a slew-limited gain looked up from a loaded curve.
// ----------------------------------------------------------------------------
// A shared restoring divider yields one quotient bit per cycle and runs
// four times per audio frame (position and offset reduction, 20 steps
// each; the Q16 phase, 36 steps; the bent phase, 31 steps), each after a
// load step, followed by curve read, slew, multiply and output steps. A
// resync runs one division and then stores the reduced start position; a
// curve write completes in its accepting beat. The block takes one item at
// a time; a result waits in the output register, and a new item is taken
// while it waits, but a frame holds in its output state until that register
// is free. Gain curve entries read as undefined until written.
// ----------------------------------------------------------------------------
module stereo_tremolo_gain_modulator_top
    import stgm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    stgm_in_if.sink                   items,
    stgm_out_if.source                results,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    stgm_controller u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_cmd   (items.cmd),
        .in_ready (items.ready),
        .cmd      (dp_cmd),
        .status   (dp_status)
    );

    stgm_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (dp_cmd),
        .status      (dp_status),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .left_in     (items.left_in),
        .right_in    (items.right_in),
        .start_frame (items.start_frame),
        .curve_index (items.curve_index),
        .curve_value (items.curve_value),
        .out_valid   (results.valid),
        .out_ready   (results.ready),
        .left_out    (results.left_out),
        .right_out   (results.right_out)
    );

endmodule

// ===== hdl/stgm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stgm_checker: port-level assertions for the tremolo gain modulator
// Watches the item and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module stgm_checker
    import stgm_pkg::*;
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [CMD_BITS-1:0]           in_cmd,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [SAMPLE_BITS-1:0] left_out,
    input logic signed [SAMPLE_BITS-1:0] right_out
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(left_out) && $stable(right_out))
        else $error("result payload changed while stalled");

    // A frame keeps the block busy after its beat
    a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_cmd == CMD_FRAME |=> !in_ready)
        else $error("item taken while a frame is in work");

    // A curve write completes within its own beat
    a_curve_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_cmd == CMD_CURVE |=> in_ready)
        else $error("curve write stalled the item channel");

    // Items other than frames raise no result
    a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_cmd != CMD_FRAME |=> !$rose(out_valid))
        else $error("result raised by a non-frame item");

endmodule

bind stereo_tremolo_gain_modulator_top stgm_checker u_stgm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .in_cmd    (items.cmd),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .left_out  (results.left_out),
    .right_out (results.right_out)
);
